/* rtl/rgbm_pkg.sv */
// ----------------------------------------------------------------------------
// RGB LED matrix PWM scan package
// Shared widths, default sizes, request kinds and the scan status record.
// ----------------------------------------------------------------------------
package rgbm_pkg;

   // Default matrix geometry and PWM phase step.
   localparam int ROWS_DEF     = 8;
   localparam int COLUMNS_DEF  = 8;
   localparam int PWM_STEP_DEF = 4;

   // Each column carries a red, a green and a blue channel.
   localparam int CHANNELS = 3;
   // The result carries enables for at most this many columns.
   localparam int OUT_COLS = 8;

   localparam int BYTE_W    = 8;
   localparam int ROW_OUT_W = 3;
   localparam int PHASE_W   = 8;

   // Stream payload widths.
   localparam int REQ_DATA_W = 8;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 32;

   // Request kinds carried on req_tuser.
   localparam logic ACTION_TICK = 1'b0;
   localparam logic ACTION_BYTE = 1'b1;

   // Scan state captured for a display tick.
   typedef struct packed {
      logic                   frame_valid;
      logic [PHASE_W-1:0]     phase;
      logic [ROW_OUT_W-1:0]   row;
   } scan_info_type;

endpackage

/* rtl/rgbm_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read and read enable.
// ----------------------------------------------------------------------------
module rgbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/rgbm_scan_ctrl.sv */
// ----------------------------------------------------------------------------
// RGB LED matrix scan control
// Keeps the frame write position, the front frame select, the PWM phase and
// the scanned row, and drives the frame store write and read ports.
// ----------------------------------------------------------------------------
module rgbm_scan_ctrl #(
   parameter int ROWS     = 8,
   parameter int COLUMNS  = 8,
   parameter int PWM_STEP = 4,
   localparam int ROW_W   = $clog2(ROWS),
   localparam int LANE_W  = $clog2(COLUMNS * 3),
   localparam int ADDR_W  = ROW_W + 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    tick_accept,
   input  logic                    byte_accept,
   output logic                    wr_en,
   output logic [LANE_W-1:0]       wr_lane,
   output logic [ADDR_W-1:0]       wr_addr,
   output logic                    rd_en,
   output logic [ADDR_W-1:0]       rd_addr,
   output rgbm_pkg::scan_info_type info
);

   import rgbm_pkg::*;

   localparam int LANES = COLUMNS * CHANNELS;
   localparam logic [PHASE_W:0] STEP = (PHASE_W + 1)'(PWM_STEP);

   logic [LANE_W-1:0]  wr_lane_ff, wr_lane_in;
   logic [ROW_W-1:0]   wr_row_ff, wr_row_in;
   logic               front_ff, front_in;
   logic [1:0]         frame_valid_ff, frame_valid_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [ROW_W-1:0]   scan_row_ff, scan_row_in;

   logic               lane_last;
   logic               row_last;
   logic [PHASE_W:0]   phase_sum;
   logic [ROW_W+2:0]   row_ext;

   assign lane_last = (wr_lane_ff == LANE_W'(LANES - 1));
   assign row_last  = (wr_row_ff == ROW_W'(ROWS - 1));
   assign phase_sum = {1'b0, phase_ff} + STEP;

   always_comb begin
      wr_lane_in     = wr_lane_ff;
      wr_row_in      = wr_row_ff;
      front_in       = front_ff;
      frame_valid_in = frame_valid_ff;
      phase_in       = phase_ff;
      scan_row_in    = scan_row_ff;

      if (byte_accept) begin
         if (lane_last) begin
            wr_lane_in = '0;
            if (row_last) begin
               // The back frame is complete: it becomes the front frame.
               wr_row_in                 = '0;
               front_in                  = ~front_ff;
               frame_valid_in[~front_ff] = 1'b1;
            end else begin
               wr_row_in = wr_row_ff + 1'b1;
            end
         end else begin
            wr_lane_in = wr_lane_ff + 1'b1;
         end
      end

      if (tick_accept) begin
         phase_in = phase_sum[PHASE_W-1:0];
         if (phase_sum[PHASE_W]) begin
            if (scan_row_ff == ROW_W'(ROWS - 1)) begin
               scan_row_in = '0;
            end else begin
               scan_row_in = scan_row_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_lane_ff     <= '0;
         wr_row_ff      <= '0;
         front_ff       <= 1'b0;
         frame_valid_ff <= '0;
         phase_ff       <= '0;
         scan_row_ff    <= '0;
      end else begin
         wr_lane_ff     <= wr_lane_in;
         wr_row_ff      <= wr_row_in;
         front_ff       <= front_in;
         frame_valid_ff <= frame_valid_in;
         phase_ff       <= phase_in;
         scan_row_ff    <= scan_row_in;
      end
   end

   // Bytes go to the back frame, ticks read the current row of the front frame.
   assign wr_en   = byte_accept;
   assign wr_lane = wr_lane_ff;
   assign wr_addr = {~front_ff, wr_row_ff};
   assign rd_en   = tick_accept;
   assign rd_addr = {front_ff, scan_row_ff};

   // The displayed row number carries the low three bits of the row counter.
   assign row_ext = {3'b000, scan_row_ff};

   always_comb begin
      info.frame_valid = frame_valid_ff[front_ff];
      info.phase       = phase_ff;
      info.row         = row_ext[ROW_OUT_W-1:0];
   end

`ifndef ASSERT_OFF
   // Completing the back frame swaps frames and marks the new front as written.
   a_swap_on_full : assert property (@(posedge clock) disable iff (reset)
      byte_accept && lane_last && row_last |=>
         (front_ff != $past(front_ff)) && frame_valid_ff[front_ff])
      else $error("frame swap missing after the last byte of a frame");

   // No swap happens in any other cycle.
   a_no_stray_swap : assert property (@(posedge clock) disable iff (reset)
      !(byte_accept && lane_last && row_last) |=> $stable(front_ff))
      else $error("front frame changed without a complete frame");

   // The row only moves when the phase wraps.
   a_row_on_wrap : assert property (@(posedge clock) disable iff (reset)
      !(tick_accept && phase_sum[PHASE_W]) |=> $stable(scan_row_ff))
      else $error("scan row advanced without a phase wrap");
`endif

endmodule

/* rtl/rgbm_pwm_compare.sv */
// ----------------------------------------------------------------------------
// RGB LED matrix PWM compare stage
// Compares the row read from the frame store with the PWM phase and holds
// the column enables in the result register.
// ----------------------------------------------------------------------------
module rgbm_pwm_compare #(
   parameter int SHOWN_COLS = 8,
   localparam int RD_W = SHOWN_COLS * 3 * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             tick_accept,
   input  rgbm_pkg::scan_info_type          info,
   input  logic [RD_W-1:0]                  rd_data,
   output logic                             take_ready,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [rgbm_pkg::ROW_OUT_W-1:0]   rsp_row,
   output logic [rgbm_pkg::OUT_COLS-1:0]    rsp_red,
   output logic [rgbm_pkg::OUT_COLS-1:0]    rsp_green,
   output logic [rgbm_pkg::OUT_COLS-1:0]    rsp_blue
);

   import rgbm_pkg::*;

   logic                 s1_valid_ff, s1_valid_in;
   scan_info_type        s1_info_ff;
   logic                 out_valid_ff, out_valid_in;
   logic [ROW_OUT_W-1:0] row_ff;
   logic [OUT_COLS-1:0]  red_ff, green_ff, blue_ff;
   logic [OUT_COLS-1:0]  red_in, green_in, blue_in;
   logic                 out_load;

   assign out_load   = !out_valid_ff || rsp_ready;
   assign take_ready = !s1_valid_ff || out_load;

   always_comb begin
      if (tick_accept) begin
         s1_valid_in = 1'b1;
      end else if (out_load) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      out_valid_in = out_load ? s1_valid_ff : out_valid_ff;
   end

   // Each shown column compares its three channel bytes with the phase.
   always_comb begin
      red_in   = '0;
      green_in = '0;
      blue_in  = '0;
      for (int c = 0; c < SHOWN_COLS; c++) begin
         red_in[c]   = s1_info_ff.frame_valid &&
                       (rd_data[(c*3+0)*BYTE_W +: BYTE_W] > s1_info_ff.phase);
         green_in[c] = s1_info_ff.frame_valid &&
                       (rd_data[(c*3+1)*BYTE_W +: BYTE_W] > s1_info_ff.phase);
         blue_in[c]  = s1_info_ff.frame_valid &&
                       (rd_data[(c*3+2)*BYTE_W +: BYTE_W] > s1_info_ff.phase);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_accept) begin
         s1_info_ff <= info;
      end
      if (out_load && s1_valid_ff) begin
         row_ff   <= s1_info_ff.row;
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_row   = row_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

`ifndef ASSERT_OFF
   // A tick never lands on a pending item that cannot move on.
   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      tick_accept |-> (!s1_valid_ff || out_load))
      else $error("tick accepted while the compare stage was blocked");

   // An accepted tick always reaches the compare stage.
   a_tick_enters : assert property (@(posedge clock) disable iff (reset)
      tick_accept |=> s1_valid_ff)
      else $error("accepted tick lost before the compare stage");

   // A blocked compare stage keeps its item.
   a_stage_holds : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_load |=> s1_valid_ff && $stable(s1_info_ff))
      else $error("blocked compare stage lost or changed its item");
`endif

endmodule

/* rtl/rgb_led_matrix_pwm_scan.sv */
// ----------------------------------------------------------------------------
// RGB LED matrix PWM scan
// Row-multiplexed PWM driver for an RGB LED matrix with a double-buffered
// frame store.
// ----------------------------------------------------------------------------
// Usage: each request on the req_ channel is either a frame byte
// (req_tuser = 1) or a display tick (req_tuser = 0). Frame bytes fill the
// back frame in row-major order, red, green and blue for each column; after
// ROWS*COLUMNS*3 bytes the frames swap and writing starts over at the first
// byte. A frame byte produces no response.
// Each tick produces one response on the rsp_ channel: the scanned row and a
// red, green and blue enable per column, set where the channel byte of the
// front frame exceeds the PWM phase. The phase then steps by PWM_STEP and the
// row advances each time the phase wraps past 255.
// A tick goes through the registered frame store read and then the compare
// into the response register before it shows on rsp_tvalid. Throughput is
// one request per cycle while req_tready stays high.
// The frame store keeps one RAM per shown column channel, one entry per row
// of each frame. Reset clears the counters and marks both frames unwritten;
// an unwritten frame displays as all dark, so no clearing pass is needed.
// When the receiver stalls, one response waits in the response register and
// one in the compare stage; req_tready drops only once both are occupied.
// ----------------------------------------------------------------------------
module rgb_led_matrix_pwm_scan #(
   parameter int ROWS     = rgbm_pkg::ROWS_DEF,
   parameter int COLUMNS  = rgbm_pkg::COLUMNS_DEF,
   parameter int PWM_STEP = rgbm_pkg::PWM_STEP_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [7:0] rx_byte
   input  logic [rgbm_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [0] action
   input  logic [rgbm_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [2:0] active_row, [10:3] red_enables, [18:11] green_enables,
   // [26:19] blue_enables, [31:27] zero
   output logic [rgbm_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   import rgbm_pkg::*;

   localparam int ROW_W      = $clog2(ROWS);
   localparam int LANE_W     = $clog2(COLUMNS * CHANNELS);
   localparam int ADDR_W     = ROW_W + 1;
   localparam int RAM_DEPTH  = 2 ** ADDR_W;
   localparam int SHOWN_COLS = (COLUMNS < OUT_COLS) ? COLUMNS : OUT_COLS;
   localparam int SHOWN_LANES = SHOWN_COLS * CHANNELS;
   localparam int PAD_W      = RSP_DATA_W - ROW_OUT_W - 3 * OUT_COLS;

   logic                        req_accept;
   logic                        tick_accept;
   logic                        byte_accept;
   logic                        wr_en;
   logic [LANE_W-1:0]           wr_lane;
   logic [ADDR_W-1:0]           wr_addr;
   logic                        rd_en;
   logic [ADDR_W-1:0]           rd_addr;
   scan_info_type               info;
   logic [SHOWN_LANES*BYTE_W-1:0] rd_data;
   logic                        take_ready;
   logic [ROW_OUT_W-1:0]        rsp_row;
   logic [OUT_COLS-1:0]         rsp_red;
   logic [OUT_COLS-1:0]         rsp_green;
   logic [OUT_COLS-1:0]         rsp_blue;

   assign req_tready  = take_ready;
   assign req_accept  = req_tvalid && req_tready;
   assign tick_accept = req_accept && (req_tuser[0] == ACTION_TICK);
   assign byte_accept = req_accept && (req_tuser[0] == ACTION_BYTE);

   rgbm_scan_ctrl #(
      .ROWS     (ROWS),
      .COLUMNS  (COLUMNS),
      .PWM_STEP (PWM_STEP)
   ) u_scan_ctrl (
      .clock       (clock),
      .reset       (reset),
      .tick_accept (tick_accept),
      .byte_accept (byte_accept),
      .wr_en       (wr_en),
      .wr_lane     (wr_lane),
      .wr_addr     (wr_addr),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .info        (info)
   );

   // One byte-wide RAM per shown column channel; columns past the result
   // width are counted in the write position but never stored.
   for (genvar l = 0; l < SHOWN_LANES; l++) begin : g_lane
      logic lane_wr_en;

      assign lane_wr_en = wr_en && (wr_lane == LANE_W'(l));

      rgbm_ram #(
         .WIDTH (BYTE_W),
         .DEPTH (RAM_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (lane_wr_en),
         .wr_addr (wr_addr),
         .wr_data (req_tdata[BYTE_W-1:0]),
         .rd_en   (rd_en),
         .rd_addr (rd_addr),
         .rd_data (rd_data[l*BYTE_W +: BYTE_W])
      );
   end

   rgbm_pwm_compare #(
      .SHOWN_COLS (SHOWN_COLS)
   ) u_pwm_compare (
      .clock       (clock),
      .reset       (reset),
      .tick_accept (tick_accept),
      .info        (info),
      .rd_data     (rd_data),
      .take_ready  (take_ready),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_row     (rsp_row),
      .rsp_red     (rsp_red),
      .rsp_green   (rsp_green),
      .rsp_blue    (rsp_blue)
   );

   assign rsp_tdata = {{PAD_W{1'b0}}, rsp_blue, rsp_green, rsp_red, rsp_row};

endmodule

/* test/tb_rgb_led_matrix_pwm_scan.sv */
// ----------------------------------------------------------------------------
// RGB LED matrix PWM scan testbench
// Streams frame bytes and display ticks into the scan block. It keeps its own
// copy of the double-buffered frame store, the PWM phase and the scan row, and
// checks every tick response field by field, in order. Both stream sides idle
// and stall at random, including one long response stall and one full drain.
// ----------------------------------------------------------------------------

// Response word as the block packs it, top bits first.
typedef struct packed {
   logic [4:0] pad;
   logic [7:0] blue;
   logic [7:0] green;
   logic [7:0] red;
   logic [2:0] row;
} scan_word_type;

// Scoreboard: predicts the scan result of every accepted tick and checks the
// responses against those predictions in order.
class matrix_scoreboard;
   localparam int N_ROWS      = rgbm_pkg::ROWS_DEF;
   localparam int N_COLS      = rgbm_pkg::COLUMNS_DEF;
   localparam int STEP        = rgbm_pkg::PWM_STEP_DEF;
   localparam int ROW_BYTES   = N_COLS * rgbm_pkg::CHANNELS;
   localparam int FRAME_BYTES = N_ROWS * ROW_BYTES;

   logic [7:0]    frames [2*FRAME_BYTES];
   bit            front;
   int unsigned   write_pos;
   int unsigned   scan_row;
   logic [7:0]    phase;
   scan_word_type scans_due[$];
   int unsigned   mismatches;

   function new();
      foreach (frames[i]) frames[i] = 8'h00;
      front      = 1'b0;
      write_pos  = 0;
      scan_row   = 0;
      phase      = 8'h00;
      mismatches = 0;
   endfunction

   function int pending();
      return scans_due.size();
   endfunction

   // Called once for every request the block has accepted.
   function void note_request(logic action, logic [7:0] value);
      int unsigned   base;
      int unsigned   sum;
      scan_word_type s;
      if (action == rgbm_pkg::ACTION_BYTE) begin
         // Bytes go to the frame that is not on display.
         frames[(front ? 0 : FRAME_BYTES) + write_pos] = value;
         write_pos++;
         if (write_pos >= FRAME_BYTES) begin
            front     = !front;
            write_pos = 0;
         end
      end else begin
         base    = (front ? FRAME_BYTES : 0) + (scan_row % N_ROWS) * ROW_BYTES;
         s       = '0;
         s.row   = 3'(scan_row);
         for (int c = 0; c < N_COLS && c < rgbm_pkg::OUT_COLS; c++) begin
            s.red[c]   = frames[base + c*3]     > phase;
            s.green[c] = frames[base + c*3 + 1] > phase;
            s.blue[c]  = frames[base + c*3 + 2] > phase;
         end
         scans_due.push_back(s);
         // The row moves on whenever the phase carries out of eight bits.
         sum   = phase + STEP;
         phase = 8'(sum);
         if (sum > 255) begin
            scan_row++;
            if (scan_row >= N_ROWS) scan_row = 0;
         end
      end
   endfunction

   task report(string what);
      if (mismatches < 40) $display("ERROR: %s", what);
      mismatches++;
   endtask

   task check_scan(logic [31:0] word);
      scan_word_type got;
      scan_word_type want;
      got = word;
      if (scans_due.size() == 0) begin
         report($sformatf("response %h arrived with no tick outstanding", word));
      end else begin
         want = scans_due.pop_front();
         if (got.row != want.row)
            report($sformatf("row %0d, want %0d", got.row, want.row));
         if (got.red != want.red)
            report($sformatf("red enables %h, want %h", got.red, want.red));
         if (got.green != want.green)
            report($sformatf("green enables %h, want %h", got.green, want.green));
         if (got.blue != want.blue)
            report($sformatf("blue enables %h, want %h", got.blue, want.blue));
         if (got.pad != want.pad)
            report($sformatf("padding bits %h are not zero", got.pad));
      end
   endtask
endclass

module tb_rgb_led_matrix_pwm_scan;
   import rgbm_pkg::*;

   localparam int FRAME_BYTES  = ROWS_DEF * COLUMNS_DEF * CHANNELS;
   // Cycles the response side holds off during the pressure test.
   localparam int LONG_STALL   = 80;
   // Cycles allowed for the pipeline to empty at the end.
   localparam int DRAIN_LIMIT  = 20000;
   localparam int RUN_LIMIT    = 3000000;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   wire                   req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // [7:0] rx_byte
   logic [REQ_USER_W-1:0] req_tuser  = '0;   // [0] action
   wire                   rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [2:0] active_row, [10:3] red, [18:11] green, [26:19] blue, [31:27] zero
   wire  [RSP_DATA_W-1:0] rsp_tdata;

   matrix_scoreboard sb;
   int  burst_left;
   int  items_sent;
   bit  long_stall_request;

   rgb_led_matrix_pwm_scan dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Every accepted response is checked at the edge that moves it.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_scan(rsp_tdata);
   end

   // Response side: stall patterns that change in segments of random length, and a
   // long hold-off when the stimulus asks for one.
   initial begin : response_side
      int seg_left;
      int mode;
      int k;
      seg_left = 0;
      mode     = 0;
      forever begin
         @(posedge clock);
         if (long_stall_request) begin
            long_stall_request = 1'b0;
            rsp_tready <= 1'b0;
            for (k = 0; k < LONG_STALL; k++) @(posedge clock);
         end else begin
            if (seg_left == 0) begin
               mode     = $urandom_range(0, 3);
               seg_left = $urandom_range(4, 60);
            end
            seg_left--;
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 4) == 0);
               default: rsp_tready <= seg_left[0];
            endcase
         end
      end
   end

   // Offers one request and waits for it to be accepted. Requests go out in
   // bursts; a new burst may start after a random gap.
   task automatic send_request(input logic action, input logic [7:0] value);
      int gap;
      if (burst_left <= 0) begin
         gap = $urandom_range(0, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(1, 30);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(action, value);
      burst_left--;
      items_sent++;
   endtask

   task automatic send_ticks(input int count);
      for (int i = 0; i < count; i++) send_request(ACTION_TICK, 8'($urandom));
   endtask

   // Channel values in several flavors: uniform, extremes, values right at
   // and next to the phase grid, and a ramp over the frame.
   function automatic logic [7:0] pick_byte(input int style, input int index);
      logic [7:0] extremes [6] = '{8'h00, 8'hFF, 8'h01, 8'hFE, 8'h80, 8'h7F};
      case (style)
         0: return 8'($urandom_range(0, 255));
         1: return extremes[$urandom_range(0, 5)];
         2: return 8'($urandom_range(0, 63) * PWM_STEP_DEF) - 8'($urandom_range(0, 1))
                   + 8'($urandom_range(0, 1));
         default: return 8'(index * 5 + 3);
      endcase
   endfunction

   // A whole frame of bytes, with ticks mixed in now and then.
   task automatic load_frame(input int style, input int tick_pct);
      for (int n = 0; n < FRAME_BYTES; n++) begin
         if ($urandom_range(0, 99) < tick_pct) send_request(ACTION_TICK, 8'($urandom));
         send_request(ACTION_BYTE, pick_byte(style, n));
      end
   endtask

   // Holds the response side off while ticks keep coming, so that the block
   // fills up and has to stall its request side.
   task automatic fill_under_stall();
      long_stall_request = 1'b1;
      burst_left = 16;
      send_ticks(12);
   endtask

   // Stops offering requests until every outstanding tick has answered.
   task automatic drain_pause();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      burst_left = 0;
   endtask

   initial begin : stimulus
      int episode;
      int pick;
      int waited;
      sb                 = new();
      burst_left         = 0;
      items_sent         = 0;
      long_stall_request = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: ticks on the dark start-up frame, and bytes at the field
      // extremes, which must not produce any response.
      send_ticks(2);
      send_request(ACTION_BYTE, 8'h00);
      send_request(ACTION_BYTE, 8'hFF);
      send_request(ACTION_BYTE, 8'h01);
      send_request(ACTION_TICK, 8'hFF);
      send_request(ACTION_BYTE, 8'hFE);
      send_request(ACTION_BYTE, 8'h80);
      send_request(ACTION_BYTE, 8'h7F);
      send_request(ACTION_BYTE, 8'h55);
      send_request(ACTION_BYTE, 8'hAA);
      send_request(ACTION_TICK, 8'h00);
      send_request(ACTION_TICK, 8'h55);

      // Random: whole frames and, more often, long tick runs, so that the
      // scan sweeps every row of fresh images; some stray requests too.
      episode = 0;
      while (items_sent < 500 || episode < 3) begin
         pick = (episode == 0) ? 0 : $urandom_range(0, 9);
         if (pick < 2) begin
            load_frame($urandom_range(0, 3), $urandom_range(0, 15));
         end else if (pick < 8) begin
            send_ticks($urandom_range(20, 120));
         end else begin
            repeat ($urandom_range(1, 12))
               send_request(1'($urandom_range(0, 1)), 8'($urandom));
         end
         episode++;
         if (episode == 1) fill_under_stall();
         if (episode == 2) drain_pause();
      end

      req_tvalid <= 1'b0;
      waited = 0;
      while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      // Keep clocking after the drain so a stray extra response would still be caught.
      repeat (10) @(posedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d ticks never answered", sb.pending()));

      if (sb.mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin : watchdog
      #(RUN_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* sim.f */
rtl/rgbm_pkg.sv
rtl/rgbm_ram.sv
rtl/rgbm_scan_ctrl.sv
rtl/rgbm_pwm_compare.sv
rtl/rgb_led_matrix_pwm_scan.sv
test/tb_rgb_led_matrix_pwm_scan.sv
